@@ hdl/toi_pkg.sv @@
// ----------------------------------------------------------------------------
// toi_pkg
// types and codes shared by the time-of-impact block and its interfaces
// ----------------------------------------------------------------------------
package toi_pkg;

    localparam int POS_W    = 20;
    localparam int VEL_W    = 16;
    localparam int RAD_W    = 16;
    localparam int STATUS_W = 3;
    localparam int TIME_W   = 32;
    localparam int CFG_IDX_W = 1;

    typedef enum logic [STATUS_W-1:0] {
        ST_HIT        = 3'd0,
        ST_CLOSING    = 3'd1,
        ST_SEPARATING = 3'd2,
        ST_NO_MOTION  = 3'd3,
        ST_MISS       = 3'd4,
        ST_PAST       = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PUCK_RADIUS   = 1'b0,
        CFG_PADDLE_RADIUS = 1'b1
    } cfg_index_t;

    localparam logic [TIME_W-1:0] TIME_NONE = '1;

endpackage

@@ hdl/toi_pair_if.sv @@
// ----------------------------------------------------------------------------
// toi_pair_if
// valid/ready channel carrying one puck/paddle pair
// ----------------------------------------------------------------------------
interface toi_pair_if;
    logic                                valid;
    logic                                ready;
    logic signed [toi_pkg::POS_W-1:0]    puck_x;
    logic signed [toi_pkg::POS_W-1:0]    puck_y;
    logic signed [toi_pkg::VEL_W-1:0]    puck_vx;
    logic signed [toi_pkg::VEL_W-1:0]    puck_vy;
    logic signed [toi_pkg::POS_W-1:0]    paddle_x;
    logic signed [toi_pkg::POS_W-1:0]    paddle_y;
    logic signed [toi_pkg::VEL_W-1:0]    paddle_vx;
    logic signed [toi_pkg::VEL_W-1:0]    paddle_vy;

    modport source (output valid, puck_x, puck_y, puck_vx, puck_vy,
                    paddle_x, paddle_y, paddle_vx, paddle_vy, input ready);
    modport sink   (input valid, puck_x, puck_y, puck_vx, puck_vy,
                    paddle_x, paddle_y, paddle_vx, paddle_vy, output ready);
endinterface

@@ hdl/toi_result_if.sv @@
// ----------------------------------------------------------------------------
// toi_result_if
// valid/ready channel carrying one contact status and time
// ----------------------------------------------------------------------------
interface toi_result_if;
    logic                              valid;
    logic                              ready;
    logic [toi_pkg::STATUS_W-1:0]      contact_status;
    logic [toi_pkg::TIME_W-1:0]        contact_time;

    modport source (output valid, contact_status, contact_time, input ready);
    modport sink   (input valid, contact_status, contact_time, output ready);
endinterface

@@ hdl/circle_time_of_impact.sv @@
// ----------------------------------------------------------------------------
// circle_time_of_impact
// first contact time of two moving circles, fully pipelined
// ----------------------------------------------------------------------------
// channel  | dir | contents
// ---------+-----+---------------------------------------------------------
// pair     | in  | puck and paddle position (Q11.8) and velocity (Q7.8)
// result   | out | contact_status, contact_time (Q16.16 frames)
// cfg      | in  | cfg_we, cfg_index, cfg_data: puck and paddle radius
//
// one transaction per cycle while the output register is not stalled
// most of the pipe is the 38-stage square root and the 32-stage divider
// the whole pipe advances when the output register is empty or taken
// rst_n resets only the valid bits and loads the default radius registers
// ----------------------------------------------------------------------------
module circle_time_of_impact
(
    input  logic                               clk,
    input  logic                               rst_n,
    toi_pair_if.sink                           pair,
    toi_result_if.source                       result,
    input  logic                               cfg_we,
    input  logic [toi_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [toi_pkg::RAD_W-1:0]          cfg_data
);

    localparam int SQ_N = 38;
    localparam int DV_N = 32;

    typedef struct packed {
        toi_pkg::status_t status;
        logic             pend;
        logic [37:0]      habs;
        logic [41:0]      cu;
        logic [75:0]      d;
        logic [41:0]      rem;
        logic [37:0]      root;
    } sq_t;

    typedef struct packed {
        toi_pkg::status_t status;
        logic             pend;
        logic [38:0]      den;
        logic [38:0]      rem;
        logic [31:0]      n;
        logic [31:0]      q;
    } dv_t;

    logic en;

    // radius registers
    logic [toi_pkg::RAD_W-1:0] puck_r_reg, paddle_r_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            puck_r_reg   <= 16'd4096;
            paddle_r_reg <= 16'd6144;
        end
        else if (cfg_we)
        begin
            unique case (toi_pkg::cfg_index_t'(cfg_index))
                toi_pkg::CFG_PUCK_RADIUS:   puck_r_reg   <= cfg_data;
                toi_pkg::CFG_PADDLE_RADIUS: paddle_r_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // valid bits
    logic s1_v_reg, s2_v_reg, s3_v_reg, s4_v_reg, s5_v_reg, den_v_reg, out_v_reg;
    logic sq_v_reg [0:SQ_N];
    logic dv_v_reg [0:DV_N];

    assign en         = !out_v_reg || result.ready;
    assign pair.ready = en;

    // stage 1: differences
    logic signed [20:0] dpx_reg, dpy_reg;
    logic signed [16:0] dvx_reg, dvy_reg;
    logic [16:0]        rs_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpx_reg <= 21'(pair.puck_x) - 21'(pair.paddle_x);
            dpy_reg <= 21'(pair.puck_y) - 21'(pair.paddle_y);
            dvx_reg <= 17'(pair.puck_vx) - 17'(pair.paddle_vx);
            dvy_reg <= 17'(pair.puck_vy) - 17'(pair.paddle_vy);
            rs_reg  <= 17'(puck_r_reg) + 17'(paddle_r_reg);
        end
    end

    // stage 2: products
    logic signed [41:0] dpx2_reg, dpy2_reg;
    logic signed [33:0] dvx2_reg, dvy2_reg;
    logic signed [37:0] pxvx_reg, pyvy_reg;
    logic [33:0]        rs2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dpx2_reg <= dpx_reg * dpx_reg;
            dpy2_reg <= dpy_reg * dpy_reg;
            dvx2_reg <= dvx_reg * dvx_reg;
            dvy2_reg <= dvy_reg * dvy_reg;
            pxvx_reg <= 38'(dpx_reg) * 38'(dvx_reg);
            pyvy_reg <= 38'(dpy_reg) * 38'(dvy_reg);
            rs2_reg  <= rs_reg * rs_reg;
        end
    end

    // stage 3: quadratic coefficients
    logic [33:0]        a_reg;
    logic signed [38:0] h_reg;
    logic signed [43:0] c_reg;
    logic signed [34:0] a_sum;

    assign a_sum = 35'(dvx2_reg) + 35'(dvy2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg <= a_sum[33:0];
            h_reg <= 39'(pxvx_reg) + 39'(pyvy_reg);
            c_reg <= 44'(dpx2_reg) + 44'(dpy2_reg) - 44'($signed({1'b0, rs2_reg}));
        end
    end

    // stage 4: classify, partial products
    toi_pkg::status_t   s4_status_reg;
    logic               s4_pend_reg, s4_hneg_reg;
    logic [37:0]        s4_habs_reg;
    logic [41:0]        s4_cu_reg;
    logic [37:0]        p0_reg, p1_reg, p2_reg;
    logic [54:0]        q0_reg, q1_reg;
    logic signed [38:0] h_abs_w;
    logic [37:0]        habs_w;
    logic               c_pos;
    toi_pkg::status_t   s4_status_next;
    logic               s4_pend_next;

    assign h_abs_w = h_reg[38] ? -h_reg : h_reg;
    assign habs_w  = h_abs_w[37:0];
    assign c_pos   = !c_reg[43] && (c_reg != '0);

    always_comb
    begin
        s4_status_next = toi_pkg::ST_HIT;
        s4_pend_next   = 1'b0;
        if (a_reg == '0)
            s4_status_next = toi_pkg::ST_NO_MOTION;
        else if (!c_pos)
            s4_status_next = h_reg[38] ? toi_pkg::ST_CLOSING : toi_pkg::ST_SEPARATING;
        else
            s4_pend_next = 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_status_reg <= s4_status_next;
            s4_pend_reg   <= s4_pend_next;
            s4_hneg_reg   <= h_reg[38];
            s4_habs_reg   <= habs_w;
            s4_cu_reg     <= c_reg[41:0];
            p0_reg        <= habs_w[18:0] * habs_w[18:0];
            p1_reg        <= habs_w[18:0] * habs_w[37:19];
            p2_reg        <= habs_w[37:19] * habs_w[37:19];
            q0_reg        <= a_reg * c_reg[20:0];
            q1_reg        <= a_reg * c_reg[41:21];
        end
    end

    // stage 5: h squared and a times c
    toi_pkg::status_t s5_status_reg;
    logic             s5_pend_reg, s5_hneg_reg;
    logic [37:0]      s5_habs_reg;
    logic [41:0]      s5_cu_reg;
    logic [75:0]      hsq_reg, ac_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s5_status_reg <= s4_status_reg;
            s5_pend_reg   <= s4_pend_reg;
            s5_hneg_reg   <= s4_hneg_reg;
            s5_habs_reg   <= s4_habs_reg;
            s5_cu_reg     <= s4_cu_reg;
            hsq_reg       <= 76'(p0_reg) + (76'(p1_reg) << 20) + (76'(p2_reg) << 38);
            ac_reg        <= 76'(q0_reg) + (76'(q1_reg) << 21);
        end
    end

    // stage 6: discriminant sign and root direction
    sq_t sq_reg [0:SQ_N];
    sq_t sq0_next;

    always_comb
    begin
        sq0_next        = '0;
        sq0_next.status = s5_status_reg;
        sq0_next.pend   = s5_pend_reg;
        sq0_next.habs   = s5_habs_reg;
        sq0_next.cu     = s5_cu_reg;
        sq0_next.d      = hsq_reg - ac_reg;
        if (s5_pend_reg)
        begin
            if (ac_reg > hsq_reg)
            begin
                sq0_next.status = toi_pkg::ST_MISS;
                sq0_next.pend   = 1'b0;
            end
            else if (!s5_hneg_reg)
            begin
                sq0_next.status = toi_pkg::ST_PAST;
                sq0_next.pend   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            sq_reg[0] <= sq0_next;
    end

    // square root, two radicand bits per stage
    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        sq_t         nxt;
        logic [41:0] remsh, trial;
        logic        ge;

        assign remsh = {sq_reg[i].rem[39:0], sq_reg[i].d[75:74]};
        assign trial = {2'b00, sq_reg[i].root, 2'b01};
        assign ge    = remsh >= trial;

        always_comb
        begin
            nxt      = sq_reg[i];
            nxt.d    = {sq_reg[i].d[73:0], 2'b00};
            nxt.rem  = ge ? (remsh - trial) : remsh;
            nxt.root = {sq_reg[i].root[36:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                sq_reg[i+1] <= nxt;
        end
    end

    // denominator
    toi_pkg::status_t den_status_reg;
    logic             den_pend_reg;
    logic [38:0]      den_reg;
    logic [41:0]      den_cu_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_status_reg <= sq_reg[SQ_N].status;
            den_pend_reg   <= sq_reg[SQ_N].pend;
            den_reg        <= 39'(sq_reg[SQ_N].habs) + 39'(sq_reg[SQ_N].root);
            den_cu_reg     <= sq_reg[SQ_N].cu;
        end
    end

    // divider setup and range check
    dv_t dv_reg [0:DV_N];
    dv_t dv0_next;

    always_comb
    begin
        dv0_next        = '0;
        dv0_next.status = den_status_reg;
        dv0_next.pend   = den_pend_reg;
        dv0_next.den    = den_reg;
        dv0_next.rem    = 39'(den_cu_reg[41:16]);
        dv0_next.n      = {den_cu_reg[15:0], 16'd0};
        if (den_pend_reg && (39'(den_cu_reg[41:16]) >= den_reg))
        begin
            dv0_next.status = toi_pkg::ST_MISS;
            dv0_next.pend   = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            dv_reg[0] <= dv0_next;
    end

    // restoring division, one quotient bit per stage
    for (genvar j = 0; j < DV_N; j++)
    begin : g_div
        dv_t         nxt;
        logic [39:0] remsh, diff;
        logic        ge;

        assign remsh = {dv_reg[j].rem, dv_reg[j].n[31]};
        assign ge    = remsh >= {1'b0, dv_reg[j].den};
        assign diff  = remsh - {1'b0, dv_reg[j].den};

        always_comb
        begin
            nxt     = dv_reg[j];
            nxt.n   = {dv_reg[j].n[30:0], 1'b0};
            nxt.rem = ge ? diff[38:0] : remsh[38:0];
            nxt.q   = {dv_reg[j].q[30:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
                dv_reg[j+1] <= nxt;
        end
    end

    // output register
    logic [toi_pkg::STATUS_W-1:0] status_reg;
    logic [toi_pkg::TIME_W-1:0]   time_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (dv_reg[DV_N].pend)
            begin
                status_reg <= toi_pkg::ST_HIT;
                time_reg   <= dv_reg[DV_N].q;
            end
            else
            begin
                status_reg <= dv_reg[DV_N].status;
                time_reg   <= (dv_reg[DV_N].status == toi_pkg::ST_CLOSING) ?
                              '0 : toi_pkg::TIME_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            s4_v_reg  <= 1'b0;
            s5_v_reg  <= 1'b0;
            den_v_reg <= 1'b0;
            out_v_reg <= 1'b0;
            for (int k = 0; k <= SQ_N; k++)
                sq_v_reg[k] <= 1'b0;
            for (int k = 0; k <= DV_N; k++)
                dv_v_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            s1_v_reg    <= pair.valid;
            s2_v_reg    <= s1_v_reg;
            s3_v_reg    <= s2_v_reg;
            s4_v_reg    <= s3_v_reg;
            s5_v_reg    <= s4_v_reg;
            sq_v_reg[0] <= s5_v_reg;
            for (int k = 1; k <= SQ_N; k++)
                sq_v_reg[k] <= sq_v_reg[k-1];
            den_v_reg   <= sq_v_reg[SQ_N];
            dv_v_reg[0] <= den_v_reg;
            for (int k = 1; k <= DV_N; k++)
                dv_v_reg[k] <= dv_v_reg[k-1];
            out_v_reg   <= dv_v_reg[DV_N];
        end
    end

    assign result.valid          = out_v_reg;
    assign result.contact_status = status_reg;
    assign result.contact_time   = time_reg;

endmodule

@@ hdl/toi_checker.sv @@
// ----------------------------------------------------------------------------
// toi_checker
// port-level checks on the time-of-impact block
// ----------------------------------------------------------------------------
module toi_checker
(
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_ready,
    input logic                               out_valid,
    input logic                               out_ready,
    input logic [toi_pkg::STATUS_W-1:0]       contact_status,
    input logic [toi_pkg::TIME_W-1:0]         contact_time
);

    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (contact_status <= toi_pkg::ST_PAST))
        else $error("status code out of range");

    a_closing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && contact_status == toi_pkg::ST_CLOSING) |-> (contact_time == '0))
        else $error("closing overlap without zero time");

    a_no_hit_ones: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (contact_status == toi_pkg::ST_SEPARATING ||
                       contact_status == toi_pkg::ST_NO_MOTION ||
                       contact_status == toi_pkg::ST_MISS ||
                       contact_status == toi_pkg::ST_PAST))
        |-> (contact_time == toi_pkg::TIME_NONE))
        else $error("no-hit result without all-ones time");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
        (out_valid && $stable(contact_status) && $stable(contact_time)))
        else $error("stalled result changed");

endmodule

bind circle_time_of_impact toi_checker u_toi_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (pair.ready),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .contact_status (result.contact_status),
    .contact_time   (result.contact_time)
);
